@@ rtl/shs_pkg.sv @@
// Package for the SHA-256 stream hasher: constants, round table, sequencer
// states and the round functions. No dependencies.
`default_nettype none

package shs_pkg;

   localparam int unsigned Rounds = 64;

   localparam logic [5:0] BlockLast = 6'd63;
   localparam logic [5:0] LenPos    = 6'd56;
   localparam logic [5:0] RoundLast = 6'd63;
   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [2:0] WordLast  = 3'd7;
   localparam logic [63:0] LenStep  = 64'd8;

   localparam logic [31:0] RoundConst [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN
   } pad_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

@@ rtl/shs_channels_if.sv @@
// Handshake channels of the SHA-256 stream hasher: message bytes in,
// digest words out. No dependencies.
`default_nettype none

interface shs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

interface shs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/sha256_stream_hasher_unit.sv @@
// SHA-256 stream hasher top level: byte packer, padding sequencer and one
// round unit shared over the 64 rounds. Depends on shs_pkg, shs_channels_if.
//
//   channel | dir | word                                   | accepted when
//   req_ch  | in  | data_byte, has_byte, end_of_message    | valid && ready
//   rsp_ch  | out | digest_word, word_index, last_word     | valid && ready
//
// A byte is taken while the sequencer is idle. Every 64th byte starts a
// compression: the rounds run through the single round unit (ST_COMP), then
// a fold into the chaining words (ST_ADD), all with req_ch.ready low.
// A finishing word pads one byte per cycle between compressions (9 to 64
// pad bytes with one compression, 65 to 72 with two), then offers eight
// digest words, one per accepted rsp word. A stalled rsp_ch holds the current word.
// reset is synchronous: chaining words back to the initial values, counts cleared.
`default_nettype none

module sha256_stream_hasher_unit
   import shs_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   shs_req_if.sink   req_ch,
   shs_rsp_if.source rsp_ch
);

   state_type   state_ff, state_in;
   pad_type     pad_ff, pad_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        finish_ff, finish_in;
   logic        last_blk_ff, last_blk_in;
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];

   logic [23:0] word_ff, word_in;
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] var_ff [8];
   logic [31:0] var_in [8];

   logic        push_en;
   logic [7:0]  push_byte;
   logic [5:0]  len_shift;
   logic [63:0] len_shifted;
   logic [7:0]  len_byte;
   logic [31:0] sched_w;
   logic [31:0] t1;
   logic [31:0] t2;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.digest_word = hash_ff[idx_ff];
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last_word   = (idx_ff == WordLast);

   // length bytes go out most significant first at fill 56..63
   assign len_shift   = {3'd7 - fill_ff[2:0], 3'b000};
   assign len_shifted = len_ff >> len_shift;
   assign len_byte    = len_shifted[7:0];

   // schedule: from round 16 on, window holds W[t-16..t-1], oldest at entry 0; earlier rounds take entry 0
   assign sched_w = (round_ff[5:4] == 2'b00) ? win_ff[0]
                  : small_sig1(win_ff[14]) + win_ff[9] + small_sig0(win_ff[1]) + win_ff[0];

   assign t1 = var_ff[7] + big_sig1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + RoundConst[round_ff] + sched_w;
   assign t2 = big_sig0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   always_comb begin
      state_in    = state_ff;
      pad_in      = pad_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      round_in    = round_ff;
      idx_in      = idx_ff;
      finish_in   = finish_ff;
      last_blk_in = last_blk_ff;
      hash_in     = hash_ff;
      word_in     = word_ff;
      win_in      = win_ff;
      var_in      = var_ff;
      push_en     = 1'b0;
      push_byte   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.has_byte) begin
                  push_en   = 1'b1;
                  push_byte = req_ch.data_byte;
                  len_in    = len_ff + LenStep;
               end
               if (req_ch.end_of_message) begin
                  finish_in = 1'b1;
                  pad_in    = PAD_MARK;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            case (pad_ff)
               PAD_MARK: begin
                  push_byte = PadByte;
                  pad_in    = PAD_ZERO;
               end
               PAD_ZERO: begin
                  if (fill_ff == LenPos) begin
                     push_byte = len_byte;
                     pad_in    = PAD_LEN;
                  end else begin
                     push_byte = '0;
                  end
               end
               PAD_LEN: begin
                  push_byte = len_byte;
                  if (fill_ff == BlockLast) begin
                     last_blk_in = 1'b1;
                  end
               end
               default: begin
                  push_byte = '0;
                  pad_in    = PAD_MARK;
               end
            endcase
         end
         ST_COMP: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = sched_w;
            var_in[7]  = var_ff[6];
            var_in[6]  = var_ff[5];
            var_in[5]  = var_ff[4];
            var_in[4]  = var_ff[3] + t1;
            var_in[3]  = var_ff[2];
            var_in[2]  = var_ff[1];
            var_in[1]  = var_ff[0];
            var_in[0]  = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == RoundLast) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int k = 0; k < 8; k++) begin
               hash_in[k] = hash_ff[k] + var_ff[k];
            end
            idx_in = '0;
            if (last_blk_ff) begin
               state_in = ST_EMIT;
            end else if (finish_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               if (idx_ff == WordLast) begin
                  hash_in     = InitHash;
                  fill_in     = '0;
                  len_in      = '0;
                  finish_in   = 1'b0;
                  last_blk_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // pack the byte; every fourth one shifts a word into the window
      if (push_en) begin
         word_in = {word_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = {word_ff, push_byte};
         end
         if (fill_ff == BlockLast) begin
            var_in   = hash_ff;
            round_in = '0;
            state_in = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pad_ff      <= PAD_MARK;
         fill_ff     <= '0;
         len_ff      <= '0;
         round_ff    <= '0;
         idx_ff      <= '0;
         finish_ff   <= 1'b0;
         last_blk_ff <= 1'b0;
         hash_ff     <= InitHash;
      end else begin
         state_ff    <= state_in;
         pad_ff      <= pad_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         round_ff    <= round_in;
         idx_ff      <= idx_in;
         finish_ff   <= finish_in;
         last_blk_ff <= last_blk_in;
         hash_ff     <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      win_ff  <= win_in;
      var_ff  <= var_in;
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while digest is offered");

   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (fill_ff == 6'd0))
      else $error("digest offered with bytes pending");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_word)
      |=> (rsp_ch.valid && rsp_ch.word_index == $past(rsp_ch.word_index) + 3'd1))
      else $error("digest word index skipped");

   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last_word)
      |=> (req_ch.ready && len_ff == 64'd0 && hash_ff[0] == InitHash[0]))
      else $error("state not restarted after digest");
`endif

endmodule

`default_nettype wire
